// ===== hdl/sacr_pkg.sv =====
// sacr_pkg: constants, types and helper functions for the cache replacement unit
// no dependencies
package sacr_pkg;
  localparam int SETS = 1024;
  localparam int WAYS = 16;
  localparam int ADDR_BITS = 40;
  localparam int LEADER_SETS = 32;
  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINES = SETS * WAYS;
  localparam int LINE_W = $clog2(LINES);
  localparam int WCNT_W = $clog2(WAYS + 1);
  localparam int LEAD_W = (LEADER_SETS > 1) ? $clog2(LEADER_SETS) : 1;
  localparam int CNT_W = 48;
  localparam int AGE_W = 3;
  localparam int PSEL_W = 10;
  localparam int LFSR_W = 16;
  localparam int CMD_W = 3;
  localparam int MODE_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_WAY_W = 4;
  localparam int OUT_SET_W = 10;

  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
  localparam logic [AGE_W-1:0] AGE_INIT = 3'd1;
  localparam logic [PSEL_W-1:0] PSEL_MAX = 10'd1023;
  localparam logic [PSEL_W-1:0] PSEL_MID = 10'd512;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [6:0] BIP_RANGE = 7'd100;
  localparam logic [6:0] BIP_LIMIT = 7'd5;

  localparam logic [CMD_W-1:0] CMD_ACCESS = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PROBE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INVAL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIRTY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSTALL = 3'd4;

  localparam logic [MODE_W-1:0] MODE_LRU = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RANDOM = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SRRIP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DRRIP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIP = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ADDR_BITS-1:0] line_addr;
  } req_t;

  typedef struct packed {
    logic found;
    logic [OUT_WAY_W-1:0] way_index;
    logic [OUT_SET_W-1:0] set_number;
    logic evicted;
    logic duplicate_error;
  } rsp_t;

  // one line entry of the way memory
  typedef struct packed {
    logic valid;
    logic dirty;
    logic [AGE_W-1:0] age;
    logic [CNT_W-1:0] stamp;
    logic [ADDR_BITS-1:0] tag;
  } line_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    lfsr_step = (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
  endfunction

  // lfsr mod 100 below 5, by reciprocal multiply and correction
  function automatic logic bip_hit(input logic [LFSR_W-1:0] v);
    logic [LFSR_W+16:0] prod;
    logic [LFSR_W-1:0] q;
    logic [LFSR_W+6:0] qm;
    logic [LFSR_W-1:0] r;
    prod = {17'd0, v} * 33'd41943;
    q = {5'd0, prod[LFSR_W+16:22]};
    qm = {7'd0, q} * {{LFSR_W{1'b0}}, BIP_RANGE};
    r = v - qm[LFSR_W-1:0];
    if (r >= {9'd0, BIP_RANGE}) r = r - {9'd0, BIP_RANGE};
    bip_hit = r < {9'd0, BIP_LIMIT};
  endfunction
endpackage

// ===== hdl/sacr_if.sv =====
// sacr_if: valid/ready channel carrying one payload
// depends on nothing; payload type is given by the user
interface sacr_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/set_assoc_cache_replacement_unit.sv =====
// set_assoc_cache_replacement_unit: tag store with LRU/random/SRRIP/DRRIP/DIP replacement
// depends on sacr_pkg, sacr_if, sacr_ctrl
//
// usage: one request (command, line_addr) enters on the in_ channel; exactly
// one result (found, way_index, set_number, evicted, duplicate_error) leaves
// on the out_ channel.
// a request reads the set's ways one per cycle from a single-port line
// memory; the next request can be taken once the result has left the
// output register. An SRRIP/DRRIP install into a full set adds an ageing
// pass that reads and rewrites every way.
// in_ready is low while a request is in flight or a result waits in the
// output register; a stalled receiver therefore holds the block.
// after reset a clearing pass over all SETS*WAYS (16384) lines zeroes the line
// memory; no request is taken meanwhile, configuration writes still are.
// configuration: cfg_we with cfg_index 0 (replacement mode) or 1 (lfsr
// seed, zero loads 1), only while idle.
module set_assoc_cache_replacement_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  sacr_if.sink                              in_ch,
  sacr_if.source                            out_ch,
  input  logic                              cfg_we,
  input  logic [sacr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  logic [sacr_pkg::MODE_W-1:0] mode_r;
  logic busy, done, start, ovalid_r;
  sacr_pkg::rsp_t rsp;
  sacr_pkg::rsp_t orsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= sacr_pkg::MODE_LRU;
    else if (cfg_we && cfg_index == sacr_pkg::REG_MODE)
      mode_r <= cfg_data[sacr_pkg::MODE_W-1:0];
  end

  assign in_ch.ready = !busy && !ovalid_r;
  assign start = in_ch.valid && in_ch.ready;

  sacr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req(in_ch.data), .mode(mode_r),
    .seed_we(cfg_we && cfg_index == sacr_pkg::REG_SEED),
    .seed(cfg_data[sacr_pkg::LFSR_W-1:0]),
    .busy(busy), .done(done), .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (done) ovalid_r <= 1'b1;
    else if (out_ch.ready) ovalid_r <= 1'b0;
  end
  always_ff @(posedge clk) if (done) orsp_r <= rsp;

  assign out_ch.valid = ovalid_r;
  assign out_ch.data = orsp_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy) else $error("request taken while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("double completion");
  a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.duplicate_error |-> out_ch.data.found)
    else $error("duplicate without found");
endmodule

// ===== hdl/sacr_line_mem.sv =====
// sacr_line_mem: single-port line memory holding tag, state, age and stamp
// depends on sacr_pkg
module sacr_line_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [sacr_pkg::LINE_W-1:0] addr,
  input  sacr_pkg::line_t             wdata,
  output sacr_pkg::line_t             rdata
);
  sacr_pkg::line_t mem [sacr_pkg::LINES];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/sacr_ctrl.sv =====
// sacr_ctrl: sequencer that scans the ways of one set through the line memory
// depends on sacr_pkg and sacr_line_mem
module sacr_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  sacr_pkg::req_t                 req,
  input  logic [sacr_pkg::MODE_W-1:0]    mode,
  input  logic                           seed_we,
  input  logic [sacr_pkg::LFSR_W-1:0]    seed,
  output logic                           busy,
  output logic                           done,
  output sacr_pkg::rsp_t                 rsp
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_AGE = 4'd4;
  localparam logic [3:0] S_RD = 4'd5;
  localparam logic [3:0] S_WR = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  localparam int W = sacr_pkg::WAYS;
  localparam int WW = sacr_pkg::WAY_W;
  localparam int CW = sacr_pkg::WCNT_W;

  logic [3:0] state_r, state_nxt;
  logic [sacr_pkg::LINE_W:0] clr_r;
  logic [CW-1:0] rcnt_r;      // read address count
  logic [CW-1:0] dcnt_r;      // data count
  logic rd_v_r;
  logic [sacr_pkg::CMD_W-1:0] cmd_r;
  logic [sacr_pkg::ADDR_BITS-1:0] tag_r;
  logic [sacr_pkg::SET_W-1:0] set_r;
  logic hit_r, inv_r, agemode_r;
  logic [WW-1:0] hit_way_r, inv_way_r, lru_way_r, zero_way_r, vic_r;
  logic [sacr_pkg::CNT_W-1:0] lru_min_r;
  logic [sacr_pkg::AGE_W-1:0] age_min_r;
  logic zero_r;
  logic [sacr_pkg::CNT_W-1:0] acc_r, miss_r, evc_r;
  logic [sacr_pkg::PSEL_W-1:0] psel_r;
  logic [sacr_pkg::LFSR_W-1:0] lfsr_r;
  sacr_pkg::line_t vline_r;
  sacr_pkg::rsp_t rsp_r;
  sacr_pkg::rsp_t rsp_nxt;

  logic we;
  logic [sacr_pkg::LINE_W-1:0] maddr;
  sacr_pkg::line_t wdata, rdata;
  logic [WW-1:0] rway, dway;

  assign rway = rcnt_r[WW-1:0];
  assign dway = dcnt_r[WW-1:0];

  sacr_line_mem u_mem (.clk(clk), .we(we), .addr(maddr), .wdata(wdata), .rdata(rdata));

  logic [sacr_pkg::LFSR_W-1:0] lfsr_a;
  logic [sacr_pkg::LEAD_W-1:0] lead;
  logic is_l0, is_l1, bip;
  logic [sacr_pkg::AGE_W-1:0] ins_age;
  logic ins_stamp;
  logic [sacr_pkg::PSEL_W-1:0] psel_new;
  logic use_lfsr;

  assign lfsr_a = sacr_pkg::lfsr_step(lfsr_r);
  assign bip = sacr_pkg::bip_hit(lfsr_a);
  assign lead = (sacr_pkg::LEADER_SETS > 1) ?
                set_r[sacr_pkg::LEAD_W-1:0] : '0;
  assign is_l0 = (lead == '0);
  assign is_l1 = (sacr_pkg::LEADER_SETS > 1) && (lead == sacr_pkg::LEAD_W'(1));

  // duel outcome, selector update and lfsr use at install
  logic duel;
  always_comb begin
    psel_new = psel_r;
    use_lfsr = 1'b0;
    duel = 1'b1;
    if (is_l0) begin
      if (psel_r < sacr_pkg::PSEL_MAX) psel_new = psel_r + 1'b1;
      duel = bip;
      use_lfsr = 1'b1;
    end else if (is_l1) begin
      if (psel_r != '0) psel_new = psel_r - 1'b1;
    end else if (psel_r < sacr_pkg::PSEL_MID) begin
      duel = bip;
      use_lfsr = 1'b1;
    end
  end

  always_comb begin
    ins_age = sacr_pkg::AGE_INIT;
    ins_stamp = 1'b1;
    if (mode == sacr_pkg::MODE_DRRIP) ins_age = duel ? 3'd1 : 3'd0;
    else if (mode == sacr_pkg::MODE_DIP) ins_stamp = duel;
  end

  always_comb begin
    rsp_nxt = '0;
    rsp_nxt.set_number = set_r[sacr_pkg::OUT_SET_W-1:0];
    if (cmd_r <= sacr_pkg::CMD_DIRTY) begin
      rsp_nxt.found = hit_r;
      rsp_nxt.way_index = hit_r ? sacr_pkg::OUT_WAY_W'(hit_way_r) : '0;
    end else if (cmd_r == sacr_pkg::CMD_INSTALL) begin
      rsp_nxt.way_index = sacr_pkg::OUT_WAY_W'(vic_r);
      if (hit_r) begin
        rsp_nxt.found = 1'b1;
        rsp_nxt.duplicate_error = 1'b1;
      end else begin
        rsp_nxt.evicted = vline_r.valid;
      end
    end
  end

  logic scan_last;
  assign scan_last = (dcnt_r == CW'(W - 1)) && rd_v_r;

  always_comb begin
    state_nxt = state_r;
    we = 1'b0;
    maddr = {set_r, rway};
    wdata = rdata;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        maddr = clr_r[sacr_pkg::LINE_W-1:0];
        wdata = '0;
        if (clr_r == (sacr_pkg::LINE_W+1)'(sacr_pkg::LINES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) state_nxt = S_SCAN;
      S_SCAN: if (scan_last) state_nxt = S_DECIDE;
      S_DECIDE: begin
        state_nxt = S_RD;
        if (!hit_r && !inv_r && cmd_r == sacr_pkg::CMD_INSTALL &&
            (mode == sacr_pkg::MODE_SRRIP || mode == sacr_pkg::MODE_DRRIP))
          state_nxt = S_AGE;
      end
      S_AGE: begin
        maddr = {set_r, dway};
        if (rd_v_r) begin
          we = 1'b1;
          wdata = rdata;
          wdata.age = rdata.age - age_min_r;
          if (dcnt_r == CW'(W - 1)) state_nxt = S_RD;
        end
      end
      S_RD: begin
        maddr = {set_r, vic_r};
        if (rd_v_r) state_nxt = S_WR;
      end
      S_WR: begin
        maddr = {set_r, vic_r};
        state_nxt = S_DONE;
        if (cmd_r == sacr_pkg::CMD_INSTALL) begin
          if (!hit_r) begin
            we = 1'b1;
            wdata.valid = 1'b1;
            wdata.dirty = 1'b0;
            wdata.tag = tag_r;
            wdata.age = ins_age;
            wdata.stamp = ins_stamp ? acc_r : vline_r.stamp;
          end
        end else if (hit_r && cmd_r <= sacr_pkg::CMD_DIRTY) begin
          we = (cmd_r != sacr_pkg::CMD_PROBE);
          if (cmd_r == sacr_pkg::CMD_ACCESS) begin
            wdata.stamp = acc_r;
            wdata.age = sacr_pkg::AGE_MAX;
          end else if (cmd_r == sacr_pkg::CMD_INVAL) wdata.valid = 1'b0;
          else wdata.dirty = 1'b1;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [3:0] unused_ctrl;
  assign unused_ctrl = {vline_r.valid, vline_r.dirty, vline_r.age[0], zero_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      acc_r <= '0;
      miss_r <= '0;
      evc_r <= '0;
      psel_r <= sacr_pkg::PSEL_MID;
      lfsr_r <= 16'd1;
      rd_v_r <= 1'b0;
      rcnt_r <= '0;
      dcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (seed_we) lfsr_r <= (seed == '0) ? 16'd1 : seed;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          rcnt_r <= '0;
          dcnt_r <= '0;
          rd_v_r <= 1'b0;
          if (start) begin
            cmd_r <= req.command;
            tag_r <= req.line_addr;
            set_r <= req.line_addr[sacr_pkg::SET_W-1:0];
            hit_r <= 1'b0;
            inv_r <= 1'b0;
            zero_r <= 1'b0;
            hit_way_r <= '0;
            inv_way_r <= '0;
            lru_way_r <= '0;
            zero_way_r <= '0;
            lru_min_r <= '1;
            age_min_r <= sacr_pkg::AGE_MAX;
            if (req.command == sacr_pkg::CMD_ACCESS) acc_r <= acc_r + 1'b1;
          end
        end
        S_SCAN: begin
          if (rcnt_r != CW'(W)) rcnt_r <= rcnt_r + 1'b1;
          rd_v_r <= (rcnt_r != CW'(W));
          if (rd_v_r) begin
            dcnt_r <= dcnt_r + 1'b1;
            if (!hit_r && rdata.valid && rdata.tag == tag_r) begin
              hit_r <= 1'b1;
              hit_way_r <= dway;
            end
            if (!inv_r && !rdata.valid) begin
              inv_r <= 1'b1;
              inv_way_r <= dway;
            end
            if (dcnt_r == '0 || rdata.stamp < lru_min_r) begin
              lru_min_r <= rdata.stamp;
              lru_way_r <= dway;
            end
            if (rdata.age < age_min_r) age_min_r <= rdata.age;
          end
        end
        S_DECIDE: begin
          rd_v_r <= 1'b0;
          rcnt_r <= '0;
          dcnt_r <= '0;
          agemode_r <= 1'b0;
          if (cmd_r == sacr_pkg::CMD_ACCESS && !hit_r) miss_r <= miss_r + 1'b1;
          if (hit_r || cmd_r != sacr_pkg::CMD_INSTALL) vic_r <= hit_way_r;
          else if (inv_r) vic_r <= inv_way_r;
          else if (mode == sacr_pkg::MODE_RANDOM) begin
            vic_r <= lfsr_a[WW-1:0];
            lfsr_r <= lfsr_a;
          end else if (mode == sacr_pkg::MODE_SRRIP || mode == sacr_pkg::MODE_DRRIP) begin
            agemode_r <= 1'b1;
            vic_r <= '0;
          end else vic_r <= lru_way_r;
        end
        S_AGE: begin
          // read one way, then write it back aged
          rd_v_r <= ~rd_v_r;
          if (rd_v_r) begin
            dcnt_r <= dcnt_r + 1'b1;
            if (!zero_r && rdata.age == age_min_r) begin
              zero_r <= 1'b1;
              zero_way_r <= dway;
              vic_r <= dway;
            end
          end
        end
        S_RD: begin
          rd_v_r <= ~rd_v_r;
          if (rd_v_r) vline_r <= rdata;
        end
        S_WR: begin
          rd_v_r <= 1'b0;
          rsp_r <= rsp_nxt;
          if (cmd_r == sacr_pkg::CMD_INSTALL && !hit_r) begin
            if (vline_r.valid) evc_r <= evc_r + 1'b1;
            if (mode == sacr_pkg::MODE_DRRIP || mode == sacr_pkg::MODE_DIP) begin
              psel_r <= psel_new;
              if (use_lfsr) lfsr_r <= lfsr_a;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign rsp = rsp_r;

  logic [2*sacr_pkg::CNT_W+WW:0] unused_stat;
  assign unused_stat = {miss_r, evc_r, zero_way_r, agemode_r};
endmodule

// ===== tb/tb_sacr_checker.sv =====
// tb_sacr_checker: watches the request, result and configuration ports of the
// cache replacement unit, predicts every result and compares it; depends on sacr_pkg
`timescale 1ns / 1ps
module tb_sacr_checker
  import sacr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  req_t                  req_data,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  rsp_t                  rsp_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  logic [ADDR_BITS-1:0] tags [LINES];
  logic                 line_valid [LINES];
  logic                 line_dirty [LINES];
  logic [AGE_W-1:0]     rrpv [LINES];
  logic [CNT_W-1:0]     stamps [LINES];
  logic [CNT_W-1:0]     access_cnt;
  logic [PSEL_W-1:0]    psel;
  logic [LFSR_W-1:0]    lfsr;
  logic [MODE_W-1:0]    mode;
  rsp_t                 expected_rsp [$];

  function automatic logic [LFSR_W-1:0] next_rand();
    lfsr = (lfsr >> 1) ^ (lfsr[0] ? 16'hB400 : 16'h0000);
    return lfsr;
  endfunction

  function automatic logic bip_draw();
    logic [LFSR_W-1:0] r;
    r = next_rand();
    return (r % 100) < 5;
  endfunction

  // set duelling, 1 means the policy-1 outcome
  function automatic logic duel(input int set);
    if (set % LEADER_SETS == 0) begin
      if (psel < PSEL_MAX) psel++;
      return bip_draw();
    end
    if (set % LEADER_SETS == 1) begin
      if (psel > 0) psel--;
      return 1'b1;
    end
    if (psel >= PSEL_MID) return 1'b1;
    return bip_draw();
  endfunction

  function automatic int pick_victim(input int base);
    int v;
    logic [AGE_W-1:0] lo;
    logic [LFSR_W-1:0] r;
    for (int w = 0; w < WAYS; w++)
      if (!line_valid[base+w]) return w;
    if (mode == MODE_RANDOM) begin
      r = next_rand();
      return r % WAYS;
    end
    if (mode == MODE_SRRIP || mode == MODE_DRRIP) begin
      lo = AGE_MAX;
      for (int w = 0; w < WAYS; w++) if (rrpv[base+w] < lo) lo = rrpv[base+w];
      for (int w = 0; w < WAYS; w++) rrpv[base+w] = rrpv[base+w] - lo;
      for (int w = 0; w < WAYS; w++) if (rrpv[base+w] == 0) return w;
      return 0;
    end
    v = 0;
    for (int w = 1; w < WAYS; w++) if (stamps[base+w] < stamps[base+v]) v = w;
    return v;
  endfunction

  function automatic rsp_t predict_lookup(input req_t rq);
    rsp_t r;
    int set, base, hit, w, e;
    logic stamp_it;
    logic [AGE_W-1:0] age;
    r = '0;
    set = int'(rq.line_addr[SET_W-1:0]);
    base = set * WAYS;
    r.set_number = OUT_SET_W'(set);
    hit = -1;
    for (int i = WAYS - 1; i >= 0; i--)
      if (line_valid[base+i] && tags[base+i] == rq.line_addr) hit = i;
    case (rq.command)
      CMD_ACCESS, CMD_PROBE, CMD_INVAL, CMD_DIRTY: begin
        if (rq.command == CMD_ACCESS) access_cnt++;
        if (hit >= 0) begin
          r.found = 1'b1;
          r.way_index = OUT_WAY_W'(hit);
          if (rq.command == CMD_ACCESS) begin
            stamps[base+hit] = access_cnt;
            rrpv[base+hit] = AGE_MAX;
          end else if (rq.command == CMD_INVAL) begin
            line_valid[base+hit] = 1'b0;
          end else if (rq.command == CMD_DIRTY) begin
            line_dirty[base+hit] = 1'b1;
          end
        end
      end
      CMD_INSTALL: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.duplicate_error = 1'b1;
          r.way_index = OUT_WAY_W'(hit);
        end else begin
          age = AGE_INIT;
          stamp_it = 1'b1;
          w = pick_victim(base);
          e = base + w;
          r.evicted = line_valid[e];
          if (mode == MODE_DRRIP) age = duel(set) ? 3'd1 : 3'd0;
          else if (mode == MODE_DIP) stamp_it = duel(set);
          tags[e] = rq.line_addr;
          line_valid[e] = 1'b1;
          line_dirty[e] = 1'b0;
          rrpv[e] = age;
          if (stamp_it) stamps[e] = access_cnt;
          r.way_index = OUT_WAY_W'(w);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        rrpv[i] = '0;
        stamps[i] = '0;
      end
      access_cnt = '0;
      psel = PSEL_MID;
      lfsr = 16'd1;
      mode = MODE_LRU;
      expected_rsp.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MODE) mode = cfg_data[MODE_W-1:0];
        else if (cfg_index == REG_SEED) lfsr = (cfg_data == 0) ? 16'd1 : cfg_data;
      end
      if (req_valid && req_ready) expected_rsp.push_back(predict_lookup(req_data));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("result with no request outstanding: %p", rsp_data);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_data.found !== want.found) begin
            $error("found: expected %0d actual %0d", want.found, rsp_data.found);
            fail_count++;
          end
          if (rsp_data.way_index !== want.way_index) begin
            $error("way_index: expected %0d actual %0d", want.way_index, rsp_data.way_index);
            fail_count++;
          end
          if (rsp_data.set_number !== want.set_number) begin
            $error("set_number: expected %0d actual %0d", want.set_number,
                   rsp_data.set_number);
            fail_count++;
          end
          if (rsp_data.evicted !== want.evicted) begin
            $error("evicted: expected %0d actual %0d", want.evicted, rsp_data.evicted);
            fail_count++;
          end
          if (rsp_data.duplicate_error !== want.duplicate_error) begin
            $error("duplicate_error: expected %0d actual %0d", want.duplicate_error,
                   rsp_data.duplicate_error);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for set_assoc_cache_replacement_unit
// depends on sacr_pkg, sacr_if and tb_sacr_checker
`timescale 1ns / 1ps
module tb_top;
  import sacr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic steady = 1'b0;
  int fail_count;
  int pending;
  int stall_left = 0;

  sacr_if #(.payload_t(req_t)) req_ch (clk);
  sacr_if #(.payload_t(rsp_t)) rsp_ch (clk);

  set_assoc_cache_replacement_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch), .out_ch(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tb_sacr_checker chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
    .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [ADDR_BITS-1:0] addr);
    int g;
    req_t rq;
    g = gap_len();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    rq.command = cmd;
    rq.line_addr = addr;
    req_ch.valid <= 1'b1;
    req_ch.data <= rq;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly a few hot sets with a small tag pool, so sets fill and evict
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    logic [SET_W-1:0] hot_sets [8] = '{0, 1, 2, 31, 32, 33, 65, 1023};
    logic [ADDR_BITS-SET_W-1:0] hi;
    if ($urandom_range(0, 99) < 20) return ADDR_BITS'({$urandom, $urandom});
    hi = (ADDR_BITS-SET_W)'($urandom_range(0, 23) * 37449281);
    return {hi, hot_sets[$urandom_range(0, 7)]};
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_INSTALL;
    if (r < 65) return CMD_ACCESS;
    if (r < 75) return CMD_PROBE;
    if (r < 85) return CMD_INVAL;
    if (r < 95) return CMD_DIRTY;
    return CMD_W'($urandom_range(5, 7));
  endfunction

  initial begin
    logic [MODE_W-1:0] modes [9] = '{MODE_LRU, MODE_RANDOM, MODE_SRRIP, MODE_DRRIP,
                                     MODE_DIP, 3'd7, MODE_DRRIP, MODE_SRRIP, MODE_DIP};
    logic [CFG_DATA_W-1:0] seeds [9] = '{16'd1, 16'hFFFF, 16'd0, 16'hACE1, 16'd1,
                                         16'h8000, 16'h1234, 16'hFFFF, 16'h5A5A};
    logic [ADDR_BITS-1:0] ones;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    ones = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every command, duplicates, unused codes
    send(CMD_ACCESS, '0);
    send(CMD_INSTALL, '0);
    send(CMD_INSTALL, '0);
    send(CMD_ACCESS, '0);
    send(CMD_PROBE, '0);
    send(CMD_DIRTY, '0);
    send(CMD_INVAL, '0);
    send(CMD_INVAL, '0);
    send(CMD_INSTALL, ones);
    send(CMD_PROBE, ones);
    send(CMD_DIRTY, ones);
    send(CMD_ACCESS, ones);
    send(3'd5, ones);
    send(3'd7, '0);
    send(3'd6, 40'h55_5555_5555);
    send(CMD_PROBE, 40'hAA_AAAA_AAAA);
    settle();

    for (int p = 0; p < 9; p++) begin
      write_reg(REG_MODE, CFG_DATA_W'(modes[p]));
      write_reg(REG_SEED, seeds[p]);
      steady = (p % 3 == 2);
      for (int i = 0; i < 100; i++) send(pick_cmd(), pick_addr());
      settle();
    end
    steady = 1'b0;

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
